/* hw/rtl/dfd_pkg.sv */
package dfd_pkg;

    // Fixed field widths of the stream
    localparam int unsigned LEN_W      = 22;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned HDR_BYTES  = 16;
    localparam int unsigned HDR_IDX_W  = 4;

    // Header byte positions
    localparam logic [HDR_IDX_W-1:0] POS_TYPE  = 4'd2;
    localparam logic [HDR_IDX_W-1:0] POS_LEN0  = 4'd12;
    localparam logic [HDR_IDX_W-1:0] POS_LEN1  = 4'd13;
    localparam logic [HDR_IDX_W-1:0] POS_LEN2  = 4'd14;
    localparam logic [HDR_IDX_W-1:0] POS_LAST  = 4'd15;

    // Register reset values
    localparam logic [BYTE_W-1:0] FRAME_TYPE_RST = 8'd3;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 22'd307200;
    localparam logic [CNT_W-1:0]  CNT_MAX        = 16'hFFFF;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd1;

    // Port packing widths
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned OUT_TUSER_W = 3;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_TYPE = 2'd1,
        ERR_LEN  = 2'd2
    } t_hdr_err;

    typedef enum logic [1:0] {
        ST_HEADER  = 2'b01,
        ST_PAYLOAD = 2'b10
    } t_fe_state;

    // One classified item between front and back
    typedef struct packed {
        logic              store_en;
        logic [LEN_W-1:0]  store_addr;
        logic [BYTE_W-1:0] store_byte;
        logic              frame_done;
        logic [LEN_W-1:0]  frame_len;
        t_hdr_err          header_error;
    } t_dfd_entry;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hw/rtl/dfd_front.sv */
module dfd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [dfd_pkg::BYTE_W-1:0]    i_in_byte,
    output logic                          o_in_ready,
    input  logic                          i_cfg_valid,
    input  logic [dfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  dfd_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output dfd_pkg::t_dfd_entry           o_entry
);
    import dfd_pkg::*;

    t_fe_state             r_state, n_state;
    logic [HDR_IDX_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]      r_addr, n_addr;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [BYTE_W-1:0]     r_type, n_type;
    logic [BYTE_W-1:0]     r_cfg_type;
    logic [LEN_W-1:0]      r_cfg_max;
    logic [LEN_W-1:0]      addr_inc;
    logic                  accept;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign addr_inc   = r_addr + 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_type <= FRAME_TYPE_RST;
            r_cfg_max  <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_TYPE: r_cfg_type <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_LEN:    r_cfg_max  <= i_cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Classify the item and advance the parser
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_addr  = r_addr;
        n_len   = r_len;
        n_type  = r_type;
        o_entry = '0;
        o_entry.header_error = ERR_NONE;
        case (r_state)
            ST_HEADER: begin
                n_idx = r_idx + 1'b1;
                case (r_idx)
                    POS_TYPE: n_type = i_in_byte;
                    POS_LEN0: n_len  = {{(LEN_W-BYTE_W){1'b0}}, i_in_byte};
                    POS_LEN1: n_len  = r_len | {{(LEN_W-2*BYTE_W){1'b0}}, i_in_byte,
                                                {BYTE_W{1'b0}}};
                    POS_LEN2: n_len  = r_len | {i_in_byte[LEN_W-2*BYTE_W-1:0],
                                                {(2*BYTE_W){1'b0}}};
                    POS_LAST: begin
                        // check the finished header
                        if (r_type != r_cfg_type) begin
                            o_entry.header_error = ERR_TYPE;
                        end else if (r_len == '0 || r_len > r_cfg_max) begin
                            o_entry.header_error = ERR_LEN;
                        end else begin
                            n_state = ST_PAYLOAD;
                            n_addr  = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_PAYLOAD: begin
                o_entry.store_en   = 1'b1;
                o_entry.store_addr = r_addr;
                o_entry.store_byte = i_in_byte;
                n_addr             = addr_inc;
                if (addr_inc >= r_len || addr_inc == '0) begin
                    o_entry.frame_done = 1'b1;
                    o_entry.frame_len  = r_len;
                    n_state            = ST_HEADER;
                    n_addr             = '0;
                    n_idx              = '0;
                end
            end
            default: begin
                n_state = ST_HEADER;
                n_idx   = '0;
                n_addr  = '0;
            end
        endcase
    end

    // Advance state on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
            r_idx   <= '0;
            r_addr  <= '0;
            r_len   <= '0;
            r_type  <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_addr  <= n_addr;
            r_len   <= n_len;
            r_type  <= n_type;
        end
    end

`ifndef SYNTHESIS
    a_addr_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAYLOAD) |-> (r_addr < r_len))
        else $error("payload offset reached frame length");
    a_hdr_idx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state == ST_PAYLOAD && o_entry.frame_done) |=> (r_idx == '0))
        else $error("header index not cleared after frame");
`endif

endmodule

/* hw/rtl/dfd_queue.sv */
module dfd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dfd_pkg::t_dfd_entry i_wr_data,
    input  logic                i_pop,
    output dfd_pkg::t_dfd_entry o_rd_data,
    output dfd_pkg::t_q_status  o_status
);
    import dfd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    t_dfd_entry        r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_QW-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_status.full  = (r_cnt == CNT_FULL);
    assign o_status.empty = (r_cnt == '0);
    assign do_push   = i_push && !o_status.full;
    assign do_pop    = i_pop && !o_status.empty;
    assign o_rd_data = r_mem[r_rd];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("queue count beyond depth");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("item pushed into full queue");
`endif

endmodule

/* hw/rtl/dfd_back.sv */
module dfd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dfd_pkg::t_q_status                   i_q_status,
    input  dfd_pkg::t_dfd_entry                  i_entry,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output dfd_pkg::t_dfd_entry                  o_out_entry,
    output logic [dfd_pkg::CNT_W-1:0]            o_out_count
);
    import dfd_pkg::*;

    logic              r_valid;
    t_dfd_entry        r_entry;
    logic [CNT_W-1:0]  r_err_cnt, n_err_cnt;
    logic [CNT_W-1:0]  r_out_cnt;

    // Pop when the output register is free or draining
    assign o_pop       = !i_q_status.empty && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_entry = r_entry;
    assign o_out_count = r_out_cnt;

    // Bump the saturating reject counter
    always_comb begin
        n_err_cnt = r_err_cnt;
        if (i_entry.header_error != ERR_NONE && r_err_cnt != CNT_MAX) begin
            n_err_cnt = r_err_cnt + 1'b1;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_err_cnt <= '0;
        end else begin
            if (o_pop) begin
                r_valid   <= 1'b1;
                r_err_cnt <= n_err_cnt;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry   <= i_entry;
            r_out_cnt <= n_err_cnt;
        end
    end

`ifndef SYNTHESIS
    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_err_cnt >= $past(r_err_cnt)))
        else $error("reject counter went down");
`endif

endmodule

/* hw/rtl/display_frame_deframer_core.sv */
// Display frame deframer. Takes one byte of a bulk stream per item, gathers a
// 16-byte little-endian header (type in byte 2, 22-bit length in bytes 12 to
// 14), checks type and length against the configured registers, then emits
// each payload byte with its offset for a frame store; the last payload byte
// carries tlast (frame done) and the length. Every input byte gives exactly
// one output item: header bytes come out with store_en low, and the last
// header byte reports the check result. The block sustains one item per clock
// while the output is not stalled. The parser is combinational and writes an
// accepted item into the queue at the accepting edge; the item then moves into
// the output register once that register is free or draining. The queue of
// QUEUE_DEPTH entries lets input keep flowing while the output stalls; s_axis
// tready falls only when it is full. Configuration writes are always ready and
// should be made while no frame is in progress; a frame already accepted runs
// to its stored length.
module display_frame_deframer_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,  // chunk_last
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [21:0] store_addr, [29:22] store_byte, [51:30] frame_len,
    // [67:52] error_count, [71:68] zero
    output logic [dfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] store_en, [2:1] header_error
    output logic [dfd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast,  // frame_done
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import dfd_pkg::*;

    t_q_status        q_status;
    t_dfd_entry       push_entry, head_entry, out_entry;
    logic             push, pop;
    logic [CNT_W-1:0] out_count;
    logic             chunk_last_unused;

    // Chunk boundaries carry no meaning for parsing
    assign chunk_last_unused = s_axis_tlast;
    assign o_cfg_ready       = 1'b1;

    dfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_byte   (s_axis_tdata),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    dfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_entry),
        .i_pop     (pop),
        .o_rd_data (head_entry),
        .o_status  (q_status)
    );

    dfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_entry (out_entry),
        .o_out_count (out_count)
    );

    // Pack the output item
    assign m_axis_tdata = {{(OUT_TDATA_W - 2*LEN_W - BYTE_W - CNT_W){chunk_last_unused & 1'b0}},
                           out_count, out_entry.frame_len,
                           out_entry.store_byte, out_entry.store_addr};
    assign m_axis_tuser = {out_entry.header_error, out_entry.store_en};
    assign m_axis_tlast = out_entry.frame_done;

endmodule

/* tb/display_frame_deframer_core_tb.sv */
`timescale 1ns / 1ps

module display_frame_deframer_core_tb;
    import dfd_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 75;
    localparam logic [LEN_W-1:0] LEN_ALL_ONES = '1;
    // Indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_in_byte;

    typedef struct packed {
        logic              store_en;
        logic [LEN_W-1:0]  store_addr;
        logic [BYTE_W-1:0] store_byte;
        logic              frame_done;
        logic [LEN_W-1:0]  frame_len;
        t_hdr_err          header_error;
        logic [CNT_W-1:0]  error_count;
    } t_store_out;

    typedef enum logic [1:0] {
        FR_GOOD,
        FR_BAD_TYPE,
        FR_BAD_LEN,
        FR_BAD_BOTH
    } t_frame_kind;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [31:0]            i_cfg_data = '0;

    display_frame_deframer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Deframer mirror: parse state and register copies
    logic              payload_active;
    logic [LEN_W-1:0]  pos_cnt;
    logic [LEN_W-1:0]  len_acc;
    logic [BYTE_W-1:0] type_seen;
    logic [CNT_W-1:0]  reject_cnt;
    logic [BYTE_W-1:0] cfg_type;
    logic [LEN_W-1:0]  cfg_max_len;

    t_in_byte   pending[$];
    t_store_out expect_q[$];
    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned carry_bytes = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    bit          no_idle = 1'b0;
    logic [15:0] rx_pat;
    logic [5:0]  rx_tick;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the mirror by one byte and return the item it should produce
    task automatic deframe_byte(input logic [7:0] b, output t_store_out r);
        logic [31:0] lane;
        r = '0;
        r.header_error = ERR_NONE;
        if (!payload_active) begin
            if (pos_cnt == POS_TYPE)
                type_seen = b;
            if (pos_cnt == POS_LEN0) begin
                len_acc = LEN_W'(b);
            end else if (pos_cnt > POS_LEN0) begin
                lane = 32'(b) << (8 * (pos_cnt - POS_LEN0));
                len_acc = len_acc | lane[LEN_W-1:0];
            end
            pos_cnt = pos_cnt + 1'b1;
            if (pos_cnt >= HDR_BYTES) begin
                pos_cnt = '0;
                if (type_seen != cfg_type) begin
                    r.header_error = ERR_TYPE;
                    if (reject_cnt != CNT_MAX) reject_cnt = reject_cnt + 1'b1;
                end else if (len_acc == '0 || len_acc > cfg_max_len) begin
                    r.header_error = ERR_LEN;
                    if (reject_cnt != CNT_MAX) reject_cnt = reject_cnt + 1'b1;
                end else begin
                    payload_active = 1'b1;
                end
            end
        end else begin
            r.store_en   = 1'b1;
            r.store_addr = pos_cnt;
            r.store_byte = b;
            pos_cnt = pos_cnt + 1'b1;
            if (pos_cnt >= len_acc || pos_cnt == '0) begin
                r.frame_done   = 1'b1;
                r.frame_len    = len_acc;
                payload_active = 1'b0;
                pos_cnt        = '0;
            end
        end
        r.error_count = reject_cnt;
    endtask

    function automatic string show_store(input t_store_out s);
        return $sformatf("en=%0b addr=%0d byte=%02h done=%0b len=%0d err=%0d cnt=%0d",
                         s.store_en, s.store_addr, s.store_byte, s.frame_done,
                         s.frame_len, s.header_error, s.error_count);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic lst);
        pending.push_back('{data: b, last: lst});
        items_queued++;
    endtask

    // Queue one header, plus its payload for a good one; a partial frame
    // leaves the rest of its payload for the next phase
    task automatic push_frame(input t_frame_kind kind, input bit partial);
        logic [7:0]  hdr[HDR_BYTES];
        t_frame_kind k;
        logic [7:0]  tv;
        int unsigned len;
        int unsigned lim;
        int unsigned n;
        k = kind;
        if (k == FR_GOOD && cfg_max_len == '0)
            k = FR_BAD_LEN;
        if (k == FR_GOOD || k == FR_BAD_LEN)
            tv = cfg_type;
        else
            tv = cfg_type ^ 8'($urandom_range(1, 255));
        case (k)
            FR_GOOD: begin
                lim = ($urandom_range(0, 9) == 0) ? 256 : 24;
                if (lim > cfg_max_len) lim = cfg_max_len;
                len = $urandom_range(1, lim);
            end
            FR_BAD_TYPE: len = $urandom & LEN_ALL_ONES;
            default: begin
                if (cfg_max_len == LEN_ALL_ONES || $urandom_range(0, 3) == 0)
                    len = 0;
                else
                    len = $urandom_range(int'(cfg_max_len) + 1, LEN_ALL_ONES);
            end
        endcase
        for (int i = 0; i < HDR_BYTES; i++)
            hdr[i] = $urandom;
        hdr[POS_TYPE]      = tv;
        hdr[POS_LEN0]      = len[7:0];
        hdr[POS_LEN1]      = len[15:8];
        hdr[POS_LEN2][5:0] = len[21:16];
        for (int i = 0; i < HDR_BYTES; i++)
            push_byte(hdr[i], $urandom_range(0, 1));
        if (k == FR_GOOD) begin
            n = partial ? len / 2 : len;
            for (int i = 0; i < n; i++)
                push_byte($urandom, $urandom_range(0, 1));
            carry_bytes = len - n;
        end
    endtask

    // Write one register; bits above the register width carry noise
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] keep;
        keep = (idx == CFG_FRAME_TYPE) ? 32'h0000_00FF : 32'h003F_FFFF;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= ($urandom & ~keep) | (value & keep);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (i_cfg_index == CFG_FRAME_TYPE)
            cfg_type = i_cfg_data[BYTE_W-1:0];
        else if (i_cfg_index == CFG_MAX_LEN)
            cfg_max_len = i_cfg_data[LEN_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every queued item went in and came back, then let it settle
    task automatic wait_idle();
        while (items_accepted != items_queued || expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Input driver: bursts with random gaps, prediction on acceptance
    always @(posedge i_clk) begin : tx_drv
        t_store_out res;
        t_in_byte   nxt;
        logic       vld;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            payload_active = 1'b0;
            pos_cnt        = '0;
            len_acc        = '0;
            type_seen      = '0;
            reject_cnt     = '0;
            cfg_type       = FRAME_TYPE_RST;
            cfg_max_len    = MAX_LEN_RST;
        end else begin
            vld = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata, res);
                expect_q.push_back(res);
                items_accepted++;
                vld = 1'b0;
            end
            if (!vld) begin
                if (gap_left != 0 && !no_idle) begin
                    gap_left--;
                end else if (pending.size() != 0) begin
                    nxt = pending.pop_front();
                    s_axis_tdata <= nxt.data;
                    s_axis_tlast <= nxt.last;
                    vld = 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_axis_tvalid <= vld;
        end
    end

    // Output monitor: compare against the oldest expectation, stall on a pattern
    always @(posedge i_clk) begin : rx_mon
        t_store_out got;
        t_store_out want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_pat  = 16'hFFFF;
            rx_tick = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.store_en     = m_axis_tuser[0];
                got.header_error = t_hdr_err'(m_axis_tuser[2:1]);
                got.frame_done   = m_axis_tlast;
                got.store_addr   = m_axis_tdata[21:0];
                got.store_byte   = m_axis_tdata[29:22];
                got.frame_len    = m_axis_tdata[51:30];
                got.error_count  = m_axis_tdata[67:52];
                if (expect_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected item %s", $realtime, show_store(got));
                    mismatches++;
                end else begin
                    want = expect_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show_store(want), show_store(got));
                        mismatches++;
                    end
                end
            end
            rx_tick = rx_tick + 1'b1;
            if (rx_tick == '0)
                rx_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            rx_pat = {rx_pat[0], rx_pat[15:1]};
            m_axis_tready <= no_idle | rx_pat[0];
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d items still expected", $realtime, expect_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned base;
        int unsigned pick;
        t_frame_kind kind;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 0) begin
                // Good frame of length 2, ignored length bits set, payload extremes
                for (int i = 0; i < HDR_BYTES; i++) begin
                    case (i)
                        POS_TYPE: push_byte(FRAME_TYPE_RST, 1'b0);
                        POS_LEN0: push_byte(8'd2, 1'b0);
                        POS_LEN1: push_byte(8'd0, 1'b1);
                        POS_LEN2: push_byte(8'hC0, 1'b0);
                        default:  push_byte(8'hFF, 1'b1);
                    endcase
                end
                push_byte(8'hFF, 1'b0);
                push_byte(8'h00, 1'b1);
                // Wrong type and zero length together: type error wins
                for (int i = 0; i < HDR_BYTES; i++)
                    push_byte(8'h00, 1'b0);
            end else begin
                wait_idle();
                case (ph)
                    1: begin
                        cfg_write(CFG_FRAME_TYPE, 32'd0);
                        cfg_write(CFG_MAX_LEN, 32'd1);
                    end
                    2: begin
                        cfg_write(CFG_FRAME_TYPE, 32'd255);
                        cfg_write(CFG_MAX_LEN, 32'(LEN_ALL_ONES));
                    end
                    3: begin
                        cfg_write(CFG_FRAME_TYPE, $urandom_range(0, 255));
                        cfg_write(CFG_MAX_LEN, 32'd0);
                    end
                    4: begin
                        cfg_write(CFG_FRAME_TYPE, $urandom_range(0, 255));
                        cfg_write(CFG_MAX_LEN, $urandom_range(16, 200));
                        cfg_write(CFG_SPARE_A, $urandom);
                        cfg_write(CFG_SPARE_B, $urandom);
                    end
                    5: begin
                        cfg_write(CFG_FRAME_TYPE, $urandom_range(0, 255));
                        cfg_write(CFG_MAX_LEN, $urandom_range(1, 64));
                    end
                    default: begin
                        cfg_write(CFG_FRAME_TYPE, 32'(FRAME_TYPE_RST));
                        cfg_write(CFG_MAX_LEN, 32'(MAX_LEN_RST));
                    end
                endcase
                // Finish the frame that was cut at the end of the last phase
                repeat (carry_bytes) push_byte($urandom, $urandom_range(0, 1));
                carry_bytes = 0;
            end

            base = items_queued;
            while (items_queued - base < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)      kind = FR_GOOD;
                else if (pick < 75) kind = FR_BAD_TYPE;
                else if (pick < 90) kind = FR_BAD_LEN;
                else                kind = FR_BAD_BOTH;
                push_frame(kind, 1'b0);
            end
            // Leave a frame open so the next register writes land mid-frame
            push_frame(FR_GOOD, 1'b1);
        end

        // Close with a run at full rate on both sides
        wait_idle();
        no_idle = 1'b1;
        repeat (carry_bytes) push_byte($urandom, $urandom_range(0, 1));
        carry_bytes = 0;
        repeat (3) push_frame(FR_BAD_TYPE, 1'b0);
        push_frame(FR_BAD_LEN, 1'b0);
        push_frame(FR_GOOD, 1'b0);

        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
